/* rtl/core/ecdec_pkg.sv */
// Shared types, codes and sizes of the e-paper controller command decoder.
package ecdec_pkg;

  localparam int GATE_ROWS    = 250;
  localparam int SOURCE_LINES = 122;
  localparam int ROW_BYTES    = 16;
  localparam int FB_ROW_BYTES = 32;
  localparam int PLANE_SIZE   = GATE_ROWS * ROW_BYTES;

  localparam int FB_INDEX_W = 12;
  localparam int COL_W      = $clog2(FB_ROW_BYTES);
  localparam int FB_ROW_W   = FB_INDEX_W - COL_W;
  localparam int X_W        = COL_W + 3;
  localparam int ROW_AW     = $clog2(GATE_ROWS);
  localparam int BYTE_W     = $clog2(ROW_BYTES);
  localparam int ROW_W      = ROW_BYTES * 8;
  localparam int ADDR_W     = 16 + BYTE_W + 1;

  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] CMD_WRITE_BW     = 8'h24;
  localparam logic [7:0] CMD_WRITE_RED    = 8'h26;
  localparam logic [7:0] CMD_ACTIVATE     = 8'h20;
  localparam logic [7:0] CMD_UPDATE_CTRL  = 8'h22;
  localparam logic [7:0] CMD_X_WINDOW     = 8'h44;
  localparam logic [7:0] CMD_X_COUNTER    = 8'h4E;
  localparam logic [7:0] CMD_GATE_COUNTER = 8'h4F;

  localparam logic [7:0]  CODE_FULL    = 8'hF7;
  localparam logic [11:0] BUSY_FULL    = 12'd3000;
  localparam logic [11:0] BUSY_PARTIAL = 12'd500;
  localparam logic [7:0]  PIXEL_MSB    = 8'h80;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WR,
    S_RD,
    S_RD_END
  } ecdec_state_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [7:0]            bus_byte;
    logic [FB_INDEX_W-1:0] fb_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        frame_done;
    logic [31:0] frame_seq;
    logic        frame_full;
    logic [11:0] busy_ms;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
  } plane_req_t;

endpackage

/* rtl/core/epaper_controller_command_decoder.sv */
// Command decoder of an e-paper controller: decodes SPI command and data bytes.
// Each transaction carries a command byte, a data byte or a framebuffer read, and yields
// exactly one result. An image data byte for the black/white plane is a read-modify-write
// of one 16-byte row of the plane memory. For a framebuffer read, the single read port of
// the plane memory fetches the eight gate rows behind the eight pixels one per cycle, and
// a final state collects the last row. The plane is white after reset without a clearing
// pass; red image data only advances the write cursor. A new transaction is taken once the
// previous one is finished and its result has left or is leaving the output register.
module epaper_controller_command_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ecdec_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ecdec_pkg::out_item_t out_item_o
);
  import ecdec_pkg::*;

  ecdec_state_e state_q, state_d;

  logic [7:0]  cmd_q, cmd_d;
  logic [2:0]  dpos_q, dpos_d;
  logic [7:0]  wx_first_q, wx_first_d;
  logic [7:0]  wx_last_q, wx_last_d;
  logic [7:0]  cnt_x_q, cnt_x_d;
  logic [15:0] cnt_gate_q, cnt_gate_d;
  logic [7:0]  cur_x_q, cur_x_d;
  logic [15:0] cur_row_q, cur_row_d;
  logic [7:0]  upd_ctrl_q, upd_ctrl_d;
  logic [31:0] seq_q, seq_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [ROW_AW-1:0] wr_row_q, wr_row_d;
  logic [BYTE_W-1:0] wr_byte_q, wr_byte_d;
  logic [7:0]        wr_val_q, wr_val_d;

  logic [COL_W-1:0]  col_q, col_d;
  logic [BYTE_W-1:0] src_byte_q, src_byte_d;
  logic [2:0]        src_bit_q, src_bit_d;
  logic [2:0]        rd_b_q, rd_b_d;
  logic [2:0]        rd_pb_q, rd_pb_d;
  logic              rd_inr_q, rd_inr_d;
  logic              rd_chk_q, rd_chk_d;
  logic [7:0]        acc_q, acc_d;

  plane_req_t        plane_req;
  logic [ROW_W-1:0]  plane_wdata;
  logic [ROW_W-1:0]  plane_rdata;

  logic              accept;
  logic [ADDR_W-1:0] wr_addr;
  logic [FB_ROW_W-1:0] fb_row;
  logic [FB_ROW_W-1:0] src_line;
  logic [FB_ROW_W-1:0] src_byte_full;
  logic [X_W-1:0]    rd_x;
  logic [7:0]        ram_byte;
  logic [7:0]        acc_next;

  ecdec_plane u_plane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (plane_req),
    .wr_data_i (plane_wdata),
    .rd_data_o (plane_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign wr_addr = ADDR_W'(cur_row_q) * ADDR_W'(ROW_BYTES) + ADDR_W'(cur_x_q);

  assign fb_row        = FB_ROW_W'(in_item_i.fb_index / FB_ROW_BYTES);
  assign src_line      = FB_ROW_W'(SOURCE_LINES - 1) - fb_row;
  assign src_byte_full = src_line >> 3;

  assign rd_x     = {col_q, 3'b000} + X_W'(rd_b_q);
  assign ram_byte = plane_rdata[src_byte_q * 8 +: 8];
  assign acc_next = (rd_chk_q && rd_inr_q && !ram_byte[3'd7 - src_bit_q]) ?
                    (acc_q | (PIXEL_MSB >> rd_pb_q)) : acc_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    dpos_d     = dpos_q;
    wx_first_d = wx_first_q;
    wx_last_d  = wx_last_q;
    cnt_x_d    = cnt_x_q;
    cnt_gate_d = cnt_gate_q;
    cur_x_d    = cur_x_q;
    cur_row_d  = cur_row_q;
    upd_ctrl_d = upd_ctrl_q;
    seq_d      = seq_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d      = out_q;
    wr_row_d   = wr_row_q;
    wr_byte_d  = wr_byte_q;
    wr_val_d   = wr_val_q;
    col_d      = col_q;
    src_byte_d = src_byte_q;
    src_bit_d  = src_bit_q;
    rd_b_d     = rd_b_q;
    rd_pb_d    = rd_pb_q;
    rd_inr_d   = rd_inr_q;
    rd_chk_d   = rd_chk_q;
    acc_d      = acc_q;
    plane_req  = '0;
    plane_wdata = plane_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d = '0;
          out_valid_d = 1'b1;
          case (in_item_i.operation)
            OP_CMD: begin
              cmd_d  = in_item_i.bus_byte;
              dpos_d = 3'd0;
              if (in_item_i.bus_byte == CMD_WRITE_BW || in_item_i.bus_byte == CMD_WRITE_RED) begin
                cur_x_d   = cnt_x_q;
                cur_row_d = cnt_gate_q;
              end else if (in_item_i.bus_byte == CMD_ACTIVATE) begin
                seq_d            = seq_q + 32'd1;
                out_d.frame_done = 1'b1;
                out_d.frame_seq  = seq_q + 32'd1;
                out_d.frame_full = (upd_ctrl_q == CODE_FULL);
                out_d.busy_ms    = (upd_ctrl_q == CODE_FULL) ? BUSY_FULL : BUSY_PARTIAL;
              end
            end
            OP_DATA: begin
              if (dpos_q < 3'd4) begin
                dpos_d = dpos_q + 3'd1;
              end
              case (cmd_q)
                CMD_X_WINDOW: begin
                  if (dpos_q == 3'd0) begin
                    wx_first_d = in_item_i.bus_byte;
                  end else if (dpos_q == 3'd1) begin
                    wx_last_d = in_item_i.bus_byte;
                  end
                end
                CMD_X_COUNTER: begin
                  if (dpos_q == 3'd0) begin
                    cnt_x_d = in_item_i.bus_byte;
                  end
                end
                CMD_GATE_COUNTER: begin
                  if (dpos_q == 3'd0) begin
                    cnt_gate_d = {8'h00, in_item_i.bus_byte};
                  end else if (dpos_q == 3'd1) begin
                    cnt_gate_d = cnt_gate_q | {in_item_i.bus_byte, 8'h00};
                  end
                end
                CMD_UPDATE_CTRL: begin
                  if (dpos_q == 3'd0) begin
                    upd_ctrl_d = in_item_i.bus_byte;
                  end
                end
                CMD_WRITE_BW, CMD_WRITE_RED: begin
                  if (cur_x_q >= wx_last_q) begin
                    cur_x_d   = wx_first_q;
                    cur_row_d = cur_row_q + 16'd1;
                  end else begin
                    cur_x_d = cur_x_q + 8'd1;
                  end
                  if (cmd_q == CMD_WRITE_BW && wr_addr < ADDR_W'(PLANE_SIZE)) begin
                    plane_req.rd_en  = 1'b1;
                    plane_req.rd_row = ROW_AW'(wr_addr / ROW_BYTES);
                    wr_row_d         = ROW_AW'(wr_addr / ROW_BYTES);
                    wr_byte_d        = BYTE_W'(wr_addr % ROW_BYTES);
                    wr_val_d         = in_item_i.bus_byte;
                    state_d          = S_WR;
                  end
                end
                default: begin
                end
              endcase
            end
            OP_READ: begin
              if (fb_row < FB_ROW_W'(SOURCE_LINES) && src_byte_full < FB_ROW_W'(ROW_BYTES)) begin
                out_valid_d = 1'b0;
                col_d       = COL_W'(in_item_i.fb_index % FB_ROW_BYTES);
                src_byte_d  = BYTE_W'(src_byte_full);
                src_bit_d   = src_line[2:0];
                rd_b_d      = 3'd0;
                rd_chk_d    = 1'b0;
                acc_d       = 8'h00;
                state_d     = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WR: begin
        plane_req.wr_en  = 1'b1;
        plane_req.wr_row = wr_row_q;
        plane_wdata[wr_byte_q * 8 +: 8] = wr_val_q;
        state_d = S_IDLE;
      end
      S_RD: begin
        plane_req.rd_en  = (rd_x < X_W'(GATE_ROWS));
        plane_req.rd_row = ROW_AW'(rd_x);
        rd_chk_d = 1'b1;
        rd_pb_d  = rd_b_q;
        rd_inr_d = (rd_x < X_W'(GATE_ROWS));
        acc_d    = acc_next;
        rd_b_d   = rd_b_q + 3'd1;
        if (rd_b_q == 3'd7) begin
          state_d = S_RD_END;
        end
      end
      S_RD_END: begin
        out_d           = '0;
        out_d.read_data = acc_next;
        out_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= 8'h00;
      dpos_q      <= 3'd0;
      wx_first_q  <= 8'h00;
      wx_last_q   <= 8'(ROW_BYTES - 1);
      cnt_x_q     <= 8'h00;
      cnt_gate_q  <= 16'h0000;
      cur_x_q     <= 8'h00;
      cur_row_q   <= 16'h0000;
      upd_ctrl_q  <= CODE_FULL;
      seq_q       <= 32'd0;
      out_valid_q <= 1'b0;
      rd_b_q      <= 3'd0;
      rd_chk_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      dpos_q      <= dpos_d;
      wx_first_q  <= wx_first_d;
      wx_last_q   <= wx_last_d;
      cnt_x_q     <= cnt_x_d;
      cnt_gate_q  <= cnt_gate_d;
      cur_x_q     <= cur_x_d;
      cur_row_q   <= cur_row_d;
      upd_ctrl_q  <= upd_ctrl_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      rd_b_q      <= rd_b_d;
      rd_chk_q    <= rd_chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    wr_row_q   <= wr_row_d;
    wr_byte_q  <= wr_byte_d;
    wr_val_q   <= wr_val_d;
    col_q      <= col_d;
    src_byte_q <= src_byte_d;
    src_bit_q  <= src_bit_d;
    rd_pb_q    <= rd_pb_d;
    rd_inr_q   <= rd_inr_d;
    acc_q      <= acc_d;
  end

endmodule

/* rtl/core/ecdec_plane.sv */
// Black/white image plane: one row of bytes per gate line, with row valid bits.
module ecdec_plane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ecdec_pkg::plane_req_t     req_i,
  input  logic [ecdec_pkg::ROW_W-1:0] wr_data_i,
  output logic [ecdec_pkg::ROW_W-1:0] rd_data_o
);
  import ecdec_pkg::*;

  logic [ROW_W-1:0]     mem [GATE_ROWS];
  logic [ROW_W-1:0]     rd_data_q;
  logic                 rd_valid_q;
  logic [GATE_ROWS-1:0] row_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_row] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_valid_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_row];
      end
    end
  end

  // A row that was never written reads as white.
  assign rd_data_o = rd_valid_q ? rd_data_q : '1;

endmodule

/* rtl/core/ecdec_checker.sv */
// Port-level checks of the command decoder and their binding to the top level.
module ecdec_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input ecdec_pkg::out_item_t out_item_o
);
  import ecdec_pkg::*;

  logic        out_take;
  logic        seen_frame_q;
  logic [31:0] last_seq_q;

  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_frame_q <= 1'b0;
      last_seq_q   <= 32'd0;
    end else if (out_take && out_item_o.frame_done) begin
      seen_frame_q <= 1'b1;
      last_seq_q   <= out_item_o.frame_seq;
    end
  end

  a_frame_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |->
      (out_item_o.frame_full && out_item_o.busy_ms == BUSY_FULL) ||
      (!out_item_o.frame_full && out_item_o.busy_ms == BUSY_PARTIAL))
    else $error("frame report carries inconsistent mode and busy time");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_done |->
      out_item_o.frame_seq == 32'd0 && !out_item_o.frame_full && out_item_o.busy_ms == 12'd0)
    else $error("frame fields set on a transaction without a frame");

  a_read_not_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_data != 8'h00 |-> !out_item_o.frame_done)
    else $error("read data and frame report in one result");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_item_o.frame_done && seen_frame_q |->
      out_item_o.frame_seq == last_seq_q + 32'd1)
    else $error("frame sequence number skipped or repeated");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind epaper_controller_command_decoder ecdec_checker u_ecdec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* test/epaper_controller_command_decoder_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the e-paper controller command decoder.
module epaper_controller_command_decoder_test;
  import ecdec_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [7:0] CMD_Y_WINDOW = 8'h45;
  localparam logic [7:0] CMD_UNKNOWN  = 8'h99;
  localparam int         STALL_LIMIT  = 5000;

  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } bus_entry_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  bus_entry_t bus_queue[$];
  out_item_t  pending_results[$];
  bit         drain_next = 1'b0;
  int         accepted_count = 0;
  int         result_count = 0;
  int         hold_left = 0;
  bit         held = 1'b0;
  int         error_count = 0;
  int         quiet_cycles = 0;

  logic [7:0]  bw_mem [PLANE_SIZE];
  logic [7:0]  win_x_first, win_x_last, cnt_x, cur_x, cur_cmd, upd_ctrl;
  logic [15:0] cnt_gate, cur_row;
  logic [2:0]  data_pos;
  logic [31:0] frame_count;

  epaper_controller_command_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic clear_decoder_state();
    for (int i = 0; i < PLANE_SIZE; i++) begin
      bw_mem[i] = 8'hFF;
    end
    win_x_first = 8'd0;
    win_x_last  = 8'(ROW_BYTES - 1);
    cnt_x       = 8'd0;
    cnt_gate    = 16'd0;
    cur_x       = 8'd0;
    cur_row     = 16'd0;
    cur_cmd     = 8'd0;
    data_pos    = 3'd0;
    upd_ctrl    = CODE_FULL;
    frame_count = 32'd0;
  endtask

  function automatic out_item_t decode_transaction(in_item_t it);
    out_item_t   res;
    logic [2:0]  pos;
    int unsigned addr, row, col, src, xg;
    res = '0;
    case (it.operation)
      OP_CMD: begin
        cur_cmd  = it.bus_byte;
        data_pos = 3'd0;
        if (it.bus_byte == CMD_WRITE_BW || it.bus_byte == CMD_WRITE_RED) begin
          cur_x   = cnt_x;
          cur_row = cnt_gate;
        end else if (it.bus_byte == CMD_ACTIVATE) begin
          frame_count    = frame_count + 32'd1;
          res.frame_done = 1'b1;
          res.frame_seq  = frame_count;
          res.frame_full = (upd_ctrl == CODE_FULL);
          res.busy_ms    = (upd_ctrl == CODE_FULL) ? BUSY_FULL : BUSY_PARTIAL;
        end
      end
      OP_DATA: begin
        pos = data_pos;
        if (data_pos < 3'd4) data_pos = data_pos + 3'd1;
        case (cur_cmd)
          CMD_X_WINDOW: begin
            if (pos == 3'd0) win_x_first = it.bus_byte;
            else if (pos == 3'd1) win_x_last = it.bus_byte;
          end
          CMD_X_COUNTER: begin
            if (pos == 3'd0) cnt_x = it.bus_byte;
          end
          CMD_GATE_COUNTER: begin
            if (pos == 3'd0) cnt_gate = {8'h00, it.bus_byte};
            else if (pos == 3'd1) cnt_gate[15:8] = it.bus_byte;
          end
          CMD_UPDATE_CTRL: begin
            if (pos == 3'd0) upd_ctrl = it.bus_byte;
          end
          CMD_WRITE_BW, CMD_WRITE_RED: begin
            addr = cur_row * ROW_BYTES + cur_x;
            if (cur_cmd == CMD_WRITE_BW && addr < PLANE_SIZE) bw_mem[addr] = it.bus_byte;
            if (cur_x >= win_x_last) begin
              cur_x   = win_x_first;
              cur_row = cur_row + 16'd1;
            end else begin
              cur_x = cur_x + 8'd1;
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        row = it.fb_index / FB_ROW_BYTES;
        col = it.fb_index % FB_ROW_BYTES;
        if (row < SOURCE_LINES) begin
          src = SOURCE_LINES - 1 - row;
          if (src / 8 < ROW_BYTES) begin
            for (int b = 0; b < 8; b++) begin
              xg = col * 8 + b;
              if (xg < GATE_ROWS && bw_mem[xg * ROW_BYTES + src / 8][7 - src % 8] == 1'b0)
                res.read_data[7 - b] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [7:0] value,
                            input logic [11:0] index);
    bus_entry_t entry;
    entry.item.operation = op;
    entry.item.bus_byte  = value;
    entry.item.fb_index  = index;
    entry.hold_for_drain = drain_next;
    drain_next = 1'b0;
    bus_queue.push_back(entry);
  endtask

  task automatic send_command(input logic [7:0] value);
    queue_item(OP_CMD, value, 12'($urandom_range(4095)));
  endtask

  task automatic send_data(input logic [7:0] value);
    queue_item(OP_DATA, value, 12'($urandom_range(4095)));
  endtask

  task automatic send_read(input logic [11:0] index);
    queue_item(OP_READ, 8'($urandom_range(255)), index);
  endtask

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    error_count++;
    if (error_count <= 10)
      $display("%s: expected read_data=%h frame_done=%b frame_seq=%0d frame_full=%b busy_ms=%0d",
               what, want.read_data, want.frame_done, want.frame_seq, want.frame_full,
               want.busy_ms);
    if (error_count <= 10)
      $display("  actual read_data=%h frame_done=%b frame_seq=%0d frame_full=%b busy_ms=%0d",
               got.read_data, got.frame_done, got.frame_seq, got.frame_full, got.busy_ms);
  endtask

  task automatic build_random_traffic();
    int          kind, count, drain_mark, src;
    logic [7:0]  sw_first, sw_last, start_x;
    logic [15:0] start_gate;
    drain_mark = 500;
    sw_first   = 8'd0;
    sw_last    = 8'd15;
    while (bus_queue.size() < 1630) begin
      if (bus_queue.size() > drain_mark) begin
        drain_next = 1'b1;
        drain_mark += 600;
      end
      kind = $urandom_range(99);
      if (kind < 35) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(9) < 8) begin
            sw_first = 8'($urandom_range(15));
            sw_last  = 8'($urandom_range(15, sw_first));
          end else begin
            sw_first = 8'($urandom_range(255));
            sw_last  = 8'($urandom_range(255));
          end
          send_command(CMD_X_WINDOW);
          send_data(sw_first);
          send_data(sw_last);
        end
        start_x    = (sw_first <= sw_last) ? 8'($urandom_range(sw_last, sw_first)) : sw_first;
        start_gate = ($urandom_range(9) < 9) ? 16'($urandom_range(GATE_ROWS - 1))
                                             : 16'($urandom_range(65535));
        send_command(CMD_X_COUNTER);
        send_data(start_x);
        send_command(CMD_GATE_COUNTER);
        send_data(start_gate[7:0]);
        send_data(start_gate[15:8]);
        send_command(($urandom_range(9) == 0) ? CMD_WRITE_RED : CMD_WRITE_BW);
        count = $urandom_range(20, 1);
        repeat (count) send_data(8'($urandom_range(255)));
        count = $urandom_range(4, 1);
        repeat (count) begin
          src = start_x * 8 + $urandom_range(7);
          if (src < SOURCE_LINES && start_gate < GATE_ROWS)
            send_read(12'((SOURCE_LINES - 1 - src) * FB_ROW_BYTES + start_gate / 8));
          else
            send_read(12'($urandom_range(3903)));
        end
      end else if (kind < 55) begin
        count = $urandom_range(4, 1);
        repeat (count) send_read(12'($urandom_range(4095)));
      end else if (kind < 70) begin
        send_command(CMD_UPDATE_CTRL);
        send_data(($urandom_range(1) == 1) ? CODE_FULL : 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) send_data(8'($urandom_range(255)));
        send_command(CMD_ACTIVATE);
      end else if (kind < 85) begin
        case ($urandom_range(5))
          0: send_command(CMD_X_WINDOW);
          1: send_command(CMD_Y_WINDOW);
          2: send_command(CMD_X_COUNTER);
          3: send_command(CMD_GATE_COUNTER);
          4: send_command(CMD_UPDATE_CTRL);
          default: send_command(8'($urandom_range(255)));
        endcase
        count = $urandom_range(5);
        repeat (count) send_data(8'($urandom_range(255)));
      end else begin
        queue_item(2'($urandom_range(3)), 8'($urandom_range(255)), 12'($urandom_range(4095)));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      in_item_i      <= '0;
      accepted_count <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(decode_transaction(in_item_i));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (bus_queue.size() != 0 &&
            !(bus_queue[0].hold_for_drain && pending_results.size() != 0) &&
            ((accepted_count >= 700 && accepted_count < 950) || $urandom_range(99) >= 23)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= bus_queue[0].item;
          void'(bus_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      result_count <= 0;
      hold_left    <= 0;
      held         <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_count <= result_count + 1;
        if (pending_results.size() == 0) begin
          note_failure("Result with no transaction outstanding", '0, out_item_o);
        end else begin
          if (out_item_o.read_data  !== pending_results[0].read_data  ||
              out_item_o.frame_done !== pending_results[0].frame_done ||
              out_item_o.frame_seq  !== pending_results[0].frame_seq  ||
              out_item_o.frame_full !== pending_results[0].frame_full ||
              out_item_o.busy_ms    !== pending_results[0].busy_ms)
            note_failure("Result mismatch", pending_results[0], out_item_o);
          void'(pending_results.pop_front());
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!held && result_count >= 400) begin
        held        <= 1'b1;
        hold_left   <= 250;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !(result_count >= 700 && result_count < 950) &&
                       $urandom_range(99) < 23;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("epaper_controller_command_decoder_test NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clear_decoder_state();
    send_command(CMD_X_COUNTER);
    send_data(8'h00);
    send_command(CMD_GATE_COUNTER);
    send_data(8'h00);
    send_data(8'h00);
    send_command(CMD_WRITE_BW);
    send_data(8'h00);
    send_data(8'h7E);
    send_read(12'(121 * FB_ROW_BYTES));
    send_command(CMD_X_WINDOW);
    send_data(8'h0F);
    send_data(8'h03);
    send_command(CMD_X_COUNTER);
    send_data(8'h20);
    send_command(CMD_GATE_COUNTER);
    send_data(8'hFF);
    send_data(8'hFF);
    send_command(CMD_WRITE_BW);
    send_data(8'h55);
    send_data(8'h33);
    send_read(12'd3903);
    send_command(CMD_ACTIVATE);
    send_command(CMD_UPDATE_CTRL);
    send_data(8'hC7);
    send_data(8'h11);
    send_command(CMD_ACTIVATE);
    send_command(CMD_Y_WINDOW);
    send_data(8'h01);
    send_command(CMD_WRITE_RED);
    send_data(8'h00);
    send_command(CMD_UNKNOWN);
    send_data(8'h12);
    queue_item(OP_UNUSED, 8'hFF, 12'hFFF);
    send_read(12'hFFF);
    build_random_traffic();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (bus_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("epaper_controller_command_decoder_test OK");
    end else begin
      $display("epaper_controller_command_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
